/* rtl/chr_pkg.sv */
`timescale 1ns / 1ps

package chr_pkg;

   localparam int HISTORY_DEPTH_DEF = 64;
   localparam int POSITION_BITS_DEF = 48;

   localparam int COMMAND_BITS    = 2;
   localparam int SLOT_FIELD_BITS = 6;

   localparam logic [COMMAND_BITS-1:0] CMD_RECORD = 2'd0;
   localparam logic [COMMAND_BITS-1:0] CMD_UNDO   = 2'd1;
   localparam logic [COMMAND_BITS-1:0] CMD_REDO   = 2'd2;
   localparam logic [COMMAND_BITS-1:0] CMD_CLEAR  = 2'd3;

   typedef logic [COMMAND_BITS-1:0] command_type;

endpackage

/* rtl/chr_ring_mem.sv */
`timescale 1ns / 1ps

module chr_ring_mem #(
   parameter int HISTORY_DEPTH = 64,
   parameter int POSITION_BITS = 48,
   parameter int IDX_W         = $clog2(HISTORY_DEPTH)
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [IDX_W-1:0]         rd_addr,
   output logic [POSITION_BITS-1:0] rd_data,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_addr,
   input  logic [POSITION_BITS-1:0] wr_data
);

   logic [POSITION_BITS-1:0] mem [HISTORY_DEPTH];
   logic [POSITION_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/chr_ctrl.sv */
`timescale 1ns / 1ps

module chr_ctrl #(
   parameter int HISTORY_DEPTH = 64,
   parameter int POSITION_BITS = 48,
   parameter int IDX_W         = $clog2(HISTORY_DEPTH)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  chr_pkg::command_type      req_cmd,
   input  logic [POSITION_BITS-1:0]  req_pos,
   output logic                      mem_rd_en,
   output logic [IDX_W-1:0]          mem_rd_addr,
   input  logic [POSITION_BITS-1:0]  mem_rd_data,
   output logic                      mem_wr_en,
   output logic [IDX_W-1:0]          mem_wr_addr,
   output logic [POSITION_BITS-1:0]  mem_wr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_moved,
   output logic [POSITION_BITS-1:0]  rsp_pos,
   output logic [IDX_W-1:0]          rsp_slot
);

   import chr_pkg::*;

   localparam int LEN_W = $clog2(HISTORY_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
   localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(HISTORY_DEPTH);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                     state_ff, state_in;
   command_type              cmd_ff;
   logic [POSITION_BITS-1:0] pos_ff;
   logic [IDX_W-1:0]         tgt_ff;
   logic [IDX_W-1:0]         cur_ff, cur_in;
   logic [IDX_W-1:0]         old_ff, old_in;
   logic [IDX_W-1:0]         new_ff, new_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_moved_ff, rsp_moved_in;
   logic [POSITION_BITS-1:0] rsp_pos_ff, rsp_pos_in;
   logic [IDX_W-1:0]         rsp_slot_ff, rsp_slot_in;

   logic             accept;
   logic             go;
   logic             full;
   logic [IDX_W-1:0] cur_next;
   logic [IDX_W-1:0] cur_prev;
   logic [LEN_W-1:0] arc_span;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign go        = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign full      = (len_ff == FULL_LEN);
   assign cur_next  = (cur_ff == LAST_IDX) ? '0 : cur_ff + 1'b1;
   assign cur_prev  = (cur_ff == '0) ? LAST_IDX : cur_ff - 1'b1;
   assign arc_span  = (cur_next >= old_ff) ? LEN_W'(cur_next) - LEN_W'(old_ff)
                                           : LEN_W'(cur_next) + FULL_LEN - LEN_W'(old_ff);

   always_comb begin
      unique case (req_cmd)
         CMD_UNDO: mem_rd_addr = cur_prev;
         CMD_REDO: mem_rd_addr = cur_next;
         default:  mem_rd_addr = cur_ff;
      endcase
   end
   assign mem_rd_en = accept;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      old_in       = old_ff;
      new_in       = new_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_moved_in = rsp_moved_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_slot_in  = rsp_slot_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = cur_next;
      mem_wr_data  = pos_ff;

      if (accept) begin
         state_in = ST_EXEC;
      end

      if (go) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         rsp_moved_in = 1'b0;
         rsp_pos_in   = '0;
         unique case (cmd_ff)
            CMD_RECORD: begin
               if (len_ff == '0) begin
                  cur_in      = '0;
                  old_in      = '0;
                  new_in      = '0;
                  len_in      = LEN_W'(1);
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = '0;
               end else if (mem_rd_data != pos_ff) begin
                  cur_in    = cur_next;
                  new_in    = cur_next;
                  mem_wr_en = 1'b1;
                  if (full) begin
                     old_in = cur_next;
                     len_in = LEN_W'(1);
                  end else begin
                     len_in = arc_span + 1'b1;
                  end
               end
            end
            CMD_UNDO: begin
               if (len_ff != '0 && (cur_ff != old_ff || full)) begin
                  cur_in       = tgt_ff;
                  rsp_moved_in = 1'b1;
                  rsp_pos_in   = mem_rd_data;
               end
            end
            CMD_REDO: begin
               if (len_ff != '0 && (cur_ff != new_ff || full)) begin
                  cur_in       = tgt_ff;
                  rsp_moved_in = 1'b1;
                  rsp_pos_in   = mem_rd_data;
               end
            end
            CMD_CLEAR: begin
               cur_in = '0;
               old_in = '0;
               new_in = '0;
               len_in = '0;
            end
         endcase
         rsp_slot_in = cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         old_ff       <= '0;
         new_ff       <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         old_ff       <= old_in;
         new_ff       <= new_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         pos_ff <= req_pos;
         tgt_ff <= mem_rd_addr;
      end
      rsp_moved_ff <= rsp_moved_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_slot_ff  <= rsp_slot_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_moved = rsp_moved_ff;
   assign rsp_pos   = rsp_pos_ff;
   assign rsp_slot  = rsp_slot_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= FULL_LEN)
      else $error("history length exceeds depth");

   a_empty_home: assert property (@(posedge clock) disable iff (reset)
      len_ff == '0 |-> cur_ff == '0 && old_ff == '0 && new_ff == '0)
      else $error("empty history with nonzero pointers");

   a_single_entry: assert property (@(posedge clock) disable iff (reset)
      len_ff == LEN_W'(1) |-> old_ff == new_ff && cur_ff == old_ff)
      else $error("single entry arc inconsistent");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC && rsp_valid_ff && !rsp_ready |=> state_ff == ST_EXEC)
      else $error("command retired into a full output register");

   a_moved_needs_history: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_moved_ff |-> len_ff != '0)
      else $error("recall reported with empty history");

endmodule

/* rtl/cursor_history_ring.sv */
`timescale 1ns / 1ps

// Cursor position history with undo and redo.
// req_*: one command transaction. req_tuser carries the command (record,
// undo, redo, clear); req_tdata carries the position in ticks, used by record.
// rsp_*: one result transaction per command. rsp_tuser is the moved flag,
// set when undo or redo recalled a stored position; rsp_tdata carries that
// position (zero when nothing moved) and the current slot index.
// Each command first reads the ring memory at the current or target slot,
// then compares, writes back and loads the output register. The next
// command is accepted only after the previous result is loaded, once the
// controller is back in idle; only one command is in flight in the
// controller at a time. The ring memory has a single read port.
// The output register holds a result until rsp_tready; while it is full a
// second command is accepted and waits in its compare stage, and req_tready
// stays low until that command retires.
// Reset empties the history at once (the occupied arc is held in pointer
// registers), points at slot 0 and drops any pending result.

module cursor_history_ring #(
   parameter int HISTORY_DEPTH = chr_pkg::HISTORY_DEPTH_DEF,
   parameter int POSITION_BITS = chr_pkg::POSITION_BITS_DEF,
   parameter int REQ_DATA_W    = ((POSITION_BITS + 7) / 8) * 8,
   parameter int RSP_DATA_W    = ((POSITION_BITS + chr_pkg::SLOT_FIELD_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // position
   input  chr_pkg::command_type  req_tuser,  // command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // recalled_position, current_slot
   output logic                  rsp_tuser   // moved
);

   import chr_pkg::*;

   localparam int IDX_W = $clog2(HISTORY_DEPTH);

   logic                     mem_rd_en;
   logic [IDX_W-1:0]         mem_rd_addr;
   logic [POSITION_BITS-1:0] mem_rd_data;
   logic                     mem_wr_en;
   logic [IDX_W-1:0]         mem_wr_addr;
   logic [POSITION_BITS-1:0] mem_wr_data;
   logic [POSITION_BITS-1:0] rsp_pos;
   logic [IDX_W-1:0]         rsp_slot;
   logic [IDX_W+SLOT_FIELD_BITS-1:0] slot_wide;

   chr_ring_mem #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .POSITION_BITS (POSITION_BITS),
      .IDX_W         (IDX_W)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   chr_ctrl #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .POSITION_BITS (POSITION_BITS),
      .IDX_W         (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (req_tuser),
      .req_pos     (req_tdata[POSITION_BITS-1:0]),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_moved   (rsp_tuser),
      .rsp_pos     (rsp_pos),
      .rsp_slot    (rsp_slot)
   );

   assign slot_wide = {{SLOT_FIELD_BITS{1'b0}}, rsp_slot};
   assign rsp_tdata = RSP_DATA_W'({slot_wide[SLOT_FIELD_BITS-1:0], rsp_pos});

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import chr_pkg::*;

   localparam int DEPTH       = HISTORY_DEPTH_DEF;
   localparam int POS_W       = POSITION_BITS_DEF;
   localparam int REQ_W       = ((POS_W + 7) / 8) * 8;
   localparam int RSP_W       = ((POS_W + SLOT_FIELD_BITS + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   typedef struct {
      bit                         moved;
      logic [POS_W-1:0]           position;
      logic [SLOT_FIELD_BITS-1:0] slot;
   } recall_result_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;   // position
   command_type      req_tuser;   // command
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;   // recalled_position, current_slot
   logic             rsp_tuser;   // moved

   logic [POS_W-1:0]           hist_pos [DEPTH];
   bit                         hist_valid [DEPTH];
   logic [SLOT_FIELD_BITS-1:0] cur_slot;
   bit                         seeded;

   recall_result_type awaited_results [$];
   recall_result_type oldest;
   bit             quiet;
   int             mismatch_count;
   int             cycle_count;
   int             commands_sent;
   int             recalls;
   int             blocked_moves;
   int             clears;
   int             full_wipes;

   cursor_history_ring dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   function automatic void wipe_history();
      for (int i = 0; i < DEPTH; i++) hist_valid[i] = 0;
      cur_slot = '0;
      seeded   = 0;
   endfunction

   task automatic apply_history_command(input command_type cmd, input logic [POS_W-1:0] pos,
                                        output recall_result_type res);
      logic [SLOT_FIELD_BITS-1:0] target;
      logic [SLOT_FIELD_BITS-1:0] scan;
      int                         dropped;
      res.moved    = 0;
      res.position = '0;
      case (cmd)
         CMD_RECORD: begin
            if (!seeded) begin
               wipe_history();
               hist_pos[0]   = pos;
               hist_valid[0] = 1;
               seeded        = 1;
            end else if (!(hist_valid[cur_slot] && hist_pos[cur_slot] == pos)) begin
               cur_slot = cur_slot + 6'd1;
               scan     = cur_slot;
               dropped  = 0;
               while (dropped < DEPTH && hist_valid[scan]) begin
                  hist_valid[scan] = 0;
                  scan             = scan + 6'd1;
                  dropped++;
               end
               if (dropped == DEPTH) full_wipes++;
               hist_pos[cur_slot]   = pos;
               hist_valid[cur_slot] = 1;
            end
         end
         CMD_UNDO, CMD_REDO: begin
            target = (cmd == CMD_UNDO) ? cur_slot - 6'd1 : cur_slot + 6'd1;
            if (hist_valid[target]) begin
               cur_slot     = target;
               res.moved    = 1;
               res.position = hist_pos[target];
               recalls++;
            end else begin
               blocked_moves++;
            end
         end
         default: begin
            wipe_history();
            clears++;
         end
      endcase
      res.slot = cur_slot;
   endtask

   task automatic send_command(input command_type cmd, input logic [POS_W-1:0] pos);
      recall_result_type res;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tuser  = cmd;
      req_tdata  = pos;
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      apply_history_command(cmd, pos, res);
      awaited_results.push_back(res);
      commands_sent++;
      @(negedge clock);
      req_tvalid = 0;
   endtask

   function automatic logic [POS_W-1:0] fresh_position();
      int roll;
      roll = $urandom_range(0, 15);
      if (roll == 0) return '0;
      if (roll == 1) return POS_MAX;
      return POS_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [POS_W-1:0] pooled_position();
      logic [POS_W-1:0] pool [8];
      pool = '{48'h0, 48'h1, 48'h32, 48'hFFFF_FFFF_FFFF, 48'h8000_0000_0000,
               48'h0000_FFFF_0000, 48'h1234_5678_9ABC, 48'h7FFF_FFFF_FFFF};
      return pool[$urandom_range(0, 7)];
   endfunction

   task automatic test_unseeded_moves();
      send_command(CMD_UNDO, fresh_position());
      send_command(CMD_REDO, fresh_position());
      send_command(CMD_CLEAR, fresh_position());
      send_command(CMD_UNDO, POS_MAX);
   endtask

   task automatic test_seed_and_repeat();
      send_command(CMD_RECORD, '0);
      send_command(CMD_RECORD, '0);
      send_command(CMD_RECORD, POS_MAX);
      send_command(CMD_RECORD, POS_MAX);
      send_command(CMD_UNDO, '0);
      send_command(CMD_UNDO, '0);
      send_command(CMD_REDO, '0);
      send_command(CMD_REDO, '0);
   endtask

   task automatic test_branch_drop();
      send_command(CMD_RECORD, 48'h0000_0000_0032);
      send_command(CMD_RECORD, 48'hAAAA_5555_AAAA);
      send_command(CMD_RECORD, 48'h5555_AAAA_5555);
      send_command(CMD_UNDO, '0);
      send_command(CMD_UNDO, '0);
      send_command(CMD_RECORD, 48'h0123_4567_89AB);
      send_command(CMD_REDO, '0);
      send_command(CMD_UNDO, '0);
   endtask

   task automatic test_clear_reseed();
      send_command(CMD_CLEAR, POS_MAX);
      send_command(CMD_REDO, '0);
      send_command(CMD_RECORD, 48'h8000_0000_0001);
      send_command(CMD_REDO, '0);
      send_command(CMD_UNDO, '0);
   endtask

   task automatic test_random_sessions(input int budget);
      int sent;
      int kind;
      int steps;
      int roll;
      sent = 0;
      while (sent < budget) begin
         kind = $urandom_range(0, 14);
         if (kind == 0) begin
            // record a run near or past the ring depth so the full history can get wiped
            steps = $urandom_range(60, 72);
            repeat (steps) send_command(CMD_RECORD, fresh_position());
            sent += steps;
         end else if (kind <= 2) begin
            steps = $urandom_range(1, 20);
            repeat (steps) send_command(CMD_UNDO, fresh_position());
            repeat (steps + 2) send_command(CMD_REDO, fresh_position());
            sent += 2 * steps + 2;
         end else begin
            steps = $urandom_range(5, 20);
            repeat (steps) begin
               roll = $urandom_range(0, 99);
               if (roll < 50)
                  send_command(CMD_RECORD, fresh_position());
               else if (roll < 60)
                  send_command(CMD_RECORD, seeded ? hist_pos[cur_slot] : fresh_position());
               else if (roll < 68)
                  send_command(CMD_RECORD, pooled_position());
               else if (roll < 83)
                  send_command(CMD_UNDO, fresh_position());
               else if (roll < 97)
                  send_command(CMD_REDO, fresh_position());
               else
                  send_command(CMD_CLEAR, fresh_position());
            end
            sent += steps;
         end
      end
   endtask

   task automatic test_back_to_back(input int budget);
      quiet = 1;
      test_random_sessions(budget);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            $error("unexpected result: tdata=%h tuser=%b", rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            oldest = awaited_results.pop_front();
            if (rsp_tuser !== oldest.moved) begin
               $error("moved: expected %0b, actual %0b", oldest.moved, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata[POS_W-1:0] !== oldest.position) begin
               $error("recalled_position: expected %h, actual %h",
                      oldest.position, rsp_tdata[POS_W-1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[POS_W+SLOT_FIELD_BITS-1:POS_W] !== oldest.slot) begin
               $error("current_slot: expected %0d, actual %0d",
                      oldest.slot, rsp_tdata[POS_W+SLOT_FIELD_BITS-1:POS_W]);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** cursor_history_ring: FAILED **");
         $finish;
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (!quiet && !reset && $urandom_range(0, 5) == 0) begin
            rsp_tready = 0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_tready = 1;
      end
   end

   initial begin
      clock          = 0;
      reset          = 1;
      req_tvalid     = 0;
      req_tdata      = '0;
      req_tuser      = CMD_RECORD;
      rsp_tready     = 0;
      quiet          = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      commands_sent  = 0;
      recalls        = 0;
      blocked_moves  = 0;
      clears         = 0;
      full_wipes     = 0;
      for (int i = 0; i < DEPTH; i++) hist_pos[i] = '0;
      wipe_history();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      test_unseeded_moves();
      test_seed_and_repeat();
      test_branch_drop();
      test_clear_reseed();
      test_random_sessions(980);
      test_back_to_back(150);

      while (awaited_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d commands: %0d recalls, %0d blocked undo/redo moves,", commands_sent,
               recalls, blocked_moves);
      $display("%0d clears and %0d full-ring wipes, with random stalls on both sides.",
               clears, full_wipes);
      if (mismatch_count == 0) begin
         $display("** cursor_history_ring: PASSED **");
      end else begin
         $display("** cursor_history_ring: FAILED **");
      end
      $finish;
   end

endmodule

/* cursor_history_ring.f */
rtl/chr_pkg.sv
rtl/chr_ring_mem.sv
rtl/chr_ctrl.sv
rtl/cursor_history_ring.sv
bench/tb_top.sv
